// ===== design/clfp_pkg.sv =====
// ----------------------------------------------------------------------------
// clfp_pkg
// Shared types and constants for the cursor list / free pool block: pool
// geometry, link encoding, item structs, controller states and datapath ops.
// ----------------------------------------------------------------------------
package clfp_pkg;

   // Pool geometry
   localparam int SLOTS     = 16;
   localparam int KEY_BITS  = 32;
   localparam int SLOT_BITS = $clog2(SLOTS);
   localparam int LINK_BITS = SLOT_BITS + 1;   // one extra bit for null

   // Field widths of the item structs
   localparam int KEY_W    = 32;
   localparam int SLOT_W   = 4;
   localparam int STATUS_W = 2;

   typedef logic [LINK_BITS-1:0] link_type;
   typedef logic [KEY_BITS-1:0]  kval_type;

   localparam link_type NULL_LINK = '1;
   localparam link_type SLOT_CNT  = LINK_BITS'(SLOTS);
   localparam link_type LINK_ONE  = LINK_BITS'(1);

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_DELETE = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE      = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2
   } status_type;

   typedef struct packed {
      op_type           opcode;
      logic [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [SLOT_W-1:0] slot;
      logic [KEY_W-1:0]  removed_key;
   } rsp_type;

   typedef enum logic [2:0] {
      CS_IDLE,
      CS_INS_START,
      CS_INS_COMMIT,
      CS_DEL_START,
      CS_DEL_CHECK,
      CS_DEL_FREE,
      CS_FINISH
   } ctl_state_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_LATCH,
      DP_INS_READ,
      DP_INS_COMMIT,
      DP_DEL_START,
      DP_DEL_STEP,
      DP_DEL_UNLINK,
      DP_DEL_FREE,
      DP_SET_FULL,
      DP_SET_MISS
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic free_empty;   // free list is empty
      logic head_null;    // key list is empty
      logic hit;          // slot just read holds the key
      logic walk_end;     // no further slot to visit
   } dp_stat_type;

   // Link names a real slot
   function automatic logic is_slot(link_type l);
      return l < SLOT_CNT;
   endfunction

endpackage

// ===== design/clfp_ctrl.sv =====
// ----------------------------------------------------------------------------
// clfp_ctrl
// Sequencer for insert and delete: steps the datapath through the pop,
// the list walk, the unlink and the free-list push, and owns the result
// valid flag.
// ----------------------------------------------------------------------------
module clfp_ctrl
   import clfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  op_type      req_opcode,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output dp_cmd_type  cmd,
   input  dp_stat_type stat
);

   ctl_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   // Output register can take a new item
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != CS_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // State and result flag registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CS_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd.op       = DP_NOP;
      cmd.load_rsp = 1'b0;
      unique case (state_ff)
         CS_IDLE: begin
            if (req_valid) begin
               cmd.op   = DP_LATCH;
               state_in = (req_opcode == OP_DELETE) ? CS_DEL_START : CS_INS_START;
            end
         end
         CS_INS_START: begin
            if (stat.free_empty) begin
               cmd.op   = DP_SET_FULL;
               state_in = CS_FINISH;
            end else begin
               cmd.op   = DP_INS_READ;
               state_in = CS_INS_COMMIT;
            end
         end
         CS_INS_COMMIT: begin
            cmd.op   = DP_INS_COMMIT;
            state_in = CS_FINISH;
         end
         CS_DEL_START: begin
            if (stat.head_null) begin
               cmd.op   = DP_SET_MISS;
               state_in = CS_FINISH;
            end else begin
               cmd.op   = DP_DEL_START;
               state_in = CS_DEL_CHECK;
            end
         end
         CS_DEL_CHECK: begin
            priority if (stat.hit) begin
               cmd.op   = DP_DEL_UNLINK;
               state_in = CS_DEL_FREE;
            end else if (stat.walk_end) begin
               cmd.op   = DP_SET_MISS;
               state_in = CS_FINISH;
            end else begin
               cmd.op   = DP_DEL_STEP;
            end
         end
         CS_DEL_FREE: begin
            cmd.op   = DP_DEL_FREE;
            state_in = CS_FINISH;
         end
         CS_FINISH: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = CS_IDLE;
            end
         end
         default: state_in = CS_IDLE;
      endcase
   end

   // Result flag: set on load, cleared when taken
   assign rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && rsp_stall);

endmodule

// ===== design/clfp_dpath.sv =====
// ----------------------------------------------------------------------------
// clfp_dpath
// Slot pool datapath: key and link memories, list and free heads, walk
// cursors, fill count for never-used slots, and the result registers.
// ----------------------------------------------------------------------------
module clfp_dpath
   import clfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_data,
   output rsp_type     rsp_data,
   input  dp_cmd_type  cmd,
   output dp_stat_type stat
);

   // Pool memories
   kval_type key_mem  [SLOTS];
   link_type link_mem [SLOTS];

   // Control state
   link_type list_head_ff, list_head_in;
   link_type free_head_ff, free_head_in;
   link_type fresh_ff, fresh_in;          // slots below this were never taken

   // Payload registers
   kval_type key_ff, key_in;
   link_type prev_ff, prev_in;
   link_type cur_ff, cur_in;
   link_type steps_ff, steps_in;
   kval_type rd_key_ff;
   link_type rd_link_ff;
   rsp_type  res_ff, res_in;
   rsp_type  rsp_ff;

   // Memory port controls
   logic                 rd_en;
   logic [SLOT_BITS-1:0] rd_addr;
   logic                 key_we;
   logic                 link_we;
   logic [SLOT_BITS-1:0] wr_addr;
   link_type             link_wdata;

   // Helpers
   logic [63:0] req_key_wide;
   logic [63:0] rd_key_wide;
   logic [31:0] slot_wide;
   logic        untouched;
   link_type    pop_next;
   link_type    walk_next;

   assign req_key_wide = 64'(req_data.key);
   assign rd_key_wide  = 64'(rd_key_ff);

   // Never-used slots chain downward: slot i follows to i-1, slot 0 to null
   assign untouched = free_head_ff < fresh_ff;
   always_comb begin
      if (untouched) begin
         pop_next = (free_head_ff == '0) ? NULL_LINK : (free_head_ff - LINK_ONE);
      end else begin
         pop_next = is_slot(rd_link_ff) ? rd_link_ff : NULL_LINK;
      end
   end
   assign walk_next = is_slot(rd_link_ff) ? rd_link_ff : NULL_LINK;

   // Status to controller
   assign stat.free_empty = !is_slot(free_head_ff);
   assign stat.head_null  = !is_slot(list_head_ff);
   assign stat.hit        = (rd_key_ff == key_ff);
   assign stat.walk_end   = !is_slot(rd_link_ff) || ((steps_ff + LINK_ONE) >= SLOT_CNT);

   // Command decode
   always_comb begin
      list_head_in = list_head_ff;
      free_head_in = free_head_ff;
      fresh_in     = fresh_ff;
      key_in       = key_ff;
      prev_in      = prev_ff;
      cur_in       = cur_ff;
      steps_in     = steps_ff;
      res_in       = res_ff;
      rd_en        = 1'b0;
      rd_addr      = free_head_ff[SLOT_BITS-1:0];
      key_we       = 1'b0;
      link_we      = 1'b0;
      wr_addr      = free_head_ff[SLOT_BITS-1:0];
      link_wdata   = list_head_ff;
      slot_wide    = '0;
      unique case (cmd.op)
         DP_NOP: begin
         end
         DP_LATCH: begin
            key_in = req_key_wide[KEY_BITS-1:0];
         end
         DP_INS_READ: begin
            rd_en   = 1'b1;
            rd_addr = free_head_ff[SLOT_BITS-1:0];
         end
         DP_INS_COMMIT: begin
            key_we       = 1'b1;
            link_we      = 1'b1;
            wr_addr      = free_head_ff[SLOT_BITS-1:0];
            link_wdata   = list_head_ff;
            list_head_in = free_head_ff;
            free_head_in = pop_next;
            if (untouched) begin
               fresh_in = free_head_ff;
            end
            slot_wide          = 32'(free_head_ff[SLOT_BITS-1:0]);
            res_in.status      = ST_DONE;
            res_in.slot        = slot_wide[SLOT_W-1:0];
            res_in.removed_key = '0;
         end
         DP_DEL_START: begin
            rd_en    = 1'b1;
            rd_addr  = list_head_ff[SLOT_BITS-1:0];
            prev_in  = NULL_LINK;
            cur_in   = list_head_ff;
            steps_in = '0;
         end
         DP_DEL_STEP: begin
            rd_en    = 1'b1;
            rd_addr  = rd_link_ff[SLOT_BITS-1:0];
            prev_in  = cur_ff;
            cur_in   = rd_link_ff;
            steps_in = steps_ff + LINK_ONE;
         end
         DP_DEL_UNLINK: begin
            if (is_slot(prev_ff)) begin
               link_we    = 1'b1;
               wr_addr    = prev_ff[SLOT_BITS-1:0];
               link_wdata = walk_next;
            end else begin
               list_head_in = walk_next;
            end
            slot_wide          = 32'(cur_ff[SLOT_BITS-1:0]);
            res_in.status      = ST_DONE;
            res_in.slot        = slot_wide[SLOT_W-1:0];
            res_in.removed_key = rd_key_wide[KEY_W-1:0];
         end
         DP_DEL_FREE: begin
            link_we      = 1'b1;
            wr_addr      = cur_ff[SLOT_BITS-1:0];
            link_wdata   = free_head_ff;
            free_head_in = cur_ff;
         end
         DP_SET_FULL: begin
            res_in.status      = ST_FULL;
            res_in.slot        = '0;
            res_in.removed_key = '0;
         end
         DP_SET_MISS: begin
            res_in.status      = ST_NOT_FOUND;
            res_in.slot        = '0;
            res_in.removed_key = '0;
         end
         default: begin
         end
      endcase
   end

   // Heads and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         list_head_ff <= NULL_LINK;
         free_head_ff <= LINK_BITS'(SLOTS - 1);
         fresh_ff     <= SLOT_CNT;
      end else begin
         list_head_ff <= list_head_in;
         free_head_ff <= free_head_in;
         fresh_ff     <= fresh_in;
      end
   end

   // Walk and result payload
   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      prev_ff  <= prev_in;
      cur_ff   <= cur_in;
      steps_ff <= steps_in;
      res_ff   <= res_in;
      if (cmd.load_rsp) begin
         rsp_ff <= res_ff;
      end
   end

   // Key memory
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[wr_addr] <= key_ff;
      end
      if (rd_en) begin
         rd_key_ff <= key_mem[rd_addr];
      end
   end

   // Link memory
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[wr_addr] <= link_wdata;
      end
      if (rd_en) begin
         rd_link_ff <= link_mem[rd_addr];
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== design/cursor_list_free_pool_core.sv =====
// ----------------------------------------------------------------------------
// cursor_list_free_pool_core
// Fixed pool of slots holding keys on one singly linked list, with unused
// slots on a free list. Insert pushes a key at the front; delete unlinks the
// first slot holding the key and returns it to the free list.
//
//   channel  ports                         item
//   input    req_valid req_stall req_data  opcode, key
//   result   rsp_valid rsp_stall rsp_data  status, slot, removed_key
//
// Insert reads the slot at the free head, then writes the key and link
// there and makes it the list head; a full pool skips both. Delete walks
// the list from the head to a hit or its end; the walk reads one slot per
// cycle from the key and link memories. One item is in work at a time.
// No clearing pass after reset: a fill count stands in for the initial free
// chain. A stalled result waits in its output register while the next item
// is taken and worked.
// ----------------------------------------------------------------------------
module cursor_list_free_pool_core
   import clfp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // Sequencer
   clfp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_data.opcode),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .cmd        (cmd),
      .stat       (stat)
   );

   // Pool datapath
   clfp_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .rsp_data (rsp_data),
      .cmd      (cmd),
      .stat     (stat)
   );

endmodule
